// ===== design/lsc_pkg.sv =====
// Shared types, constants and helpers for the lidar sweep cluster detector.
`timescale 1ns / 1ps
`default_nettype none
package lsc_pkg;

	localparam logic [15:0] FullTurn = 16'd23040;
	localparam int QueueDepth = 4;

	// register indexes
	localparam logic [2:0] RegMinDistance    = 3'd0;
	localparam logic [2:0] RegMaxDistance    = 3'd1;
	localparam logic [2:0] RegMinQuality     = 3'd2;
	localparam logic [2:0] RegWindowStart    = 3'd3;
	localparam logic [2:0] RegWindowEnd      = 3'd4;
	localparam logic [2:0] RegMaxAngleGap    = 3'd5;
	localparam logic [2:0] RegMaxDistanceGap = 3'd6;
	localparam logic [2:0] RegMaxWidth       = 3'd7;

	typedef struct packed {
		logic [15:0] min_distance;
		logic [15:0] max_distance;
		logic [5:0]  quality_floor;
		logic [14:0] window_start_angle;
		logic [14:0] window_end_angle;
		logic [14:0] max_angle_gap;
		logic [15:0] max_distance_gap;
		logic [14:0] max_cluster_width;
	} cfg_t;

	// classified point handed from front to back
	typedef struct packed {
		logic        start;
		logic        kept;
		logic        near;
		logic [14:0] angle;
		logic [15:0] distance;
	} op_t;

	function automatic logic [15:0] fwd_gap(input logic [14:0] from, input logic [14:0] to);
		logic [15:0] r;
		if (to >= from) r = {1'b0, to} - {1'b0, from};
		else r = {1'b0, to} + FullTurn - {1'b0, from};
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/lsc_front.sv =====
// Front end: angle reduction, range, quality and window test, and neighbor test per point.
`timescale 1ns / 1ps
`default_nettype none
module lsc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lsc_pkg::cfg_t       cfg,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [14:0]         angle_in,
	input  wire  [15:0]         distance_in,
	input  wire  [5:0]          quality_in,
	input  wire                 start_in,
	output logic                push,
	output lsc_pkg::op_t        op,
	input  wire                 queue_ready
);
	import lsc_pkg::*;

	logic        prev_valid_q;
	logic [14:0] prev_angle_q;
	logic [15:0] prev_distance_q;
	logic [14:0] ang;
	logic [15:0] dgap;
	logic        ang_ok;
	logic        kept;

	always_comb begin
		if ({1'b0, angle_in} >= FullTurn) ang = 15'({1'b0, angle_in} - FullTurn);
		else ang = angle_in;
		if (cfg.window_start_angle <= cfg.window_end_angle)
			ang_ok = ang >= cfg.window_start_angle && ang <= cfg.window_end_angle;
		else
			ang_ok = ang >= cfg.window_start_angle || ang <= cfg.window_end_angle;
		kept = distance_in >= cfg.min_distance && distance_in <= cfg.max_distance &&
			quality_in >= cfg.quality_floor && ang_ok;
		dgap = (distance_in >= prev_distance_q) ? distance_in - prev_distance_q
			: prev_distance_q - distance_in;
		op.start    = start_in;
		op.kept     = kept;
		op.near     = !start_in && prev_valid_q &&
			fwd_gap(prev_angle_q, ang) <= {1'b0, cfg.max_angle_gap} &&
			dgap <= cfg.max_distance_gap;
		op.angle    = ang;
		op.distance = distance_in;
	end

	assign in_ready = queue_ready;
	assign push = in_valid && queue_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_angle_q <= '0;
			prev_distance_q <= '0;
		end else if (push) begin
			prev_valid_q <= kept;
			if (kept) begin
				prev_angle_q <= ang;
				prev_distance_q <= distance_in;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/lsc_queue.sv =====
// Short queue of classified points between front and back.
`timescale 1ns / 1ps
`default_nettype none
module lsc_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lsc_pkg::op_t        push_op,
	output logic                not_full,
	input  wire                 pop,
	output logic                not_empty,
	output lsc_pkg::op_t        head
);
	import lsc_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);

	op_t               mem_q [QueueDepth];
	logic [PtrW-1:0]   wr_q;
	logic [PtrW-1:0]   rd_q;
	logic [PtrW:0]     cnt_q;

	assign not_full  = cnt_q != (PtrW+1)'(QueueDepth);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== design/lsc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the cluster average.
`timescale 1ns / 1ps
`default_nettype none
module lsc_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [25:0] dividend,
	input  wire  [9:0]  divisor,
	output logic        done,
	output logic [15:0] quotient
);
	logic [25:0] quo_q;
	logic [9:0]  rem_q;
	logic [9:0]  div_q;
	logic [4:0]  steps_q;
	logic        busy_q;
	logic [10:0] trial;
	logic        fit;

	assign trial = {rem_q, quo_q[25]};
	assign fit = trial >= {1'b0, div_q};
	assign quotient = quo_q[15:0];

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? 10'(trial - {1'b0, div_q}) : trial[9:0];
			quo_q <= {quo_q[24:0], fit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			steps_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				steps_q <= 5'd25;
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/lsc_back.sv =====
// Back end: cluster building, best cluster tracking and result register.
`timescale 1ns / 1ps
`default_nettype none
module lsc_back #(
	parameter int MIN_POINTS  = 3,
	parameter int COUNT_LIMIT = 1023
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lsc_pkg::cfg_t       cfg,
	input  wire                 op_valid,
	input  lsc_pkg::op_t        op_in,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic                out_found,
	output logic [14:0]         out_angle,
	output logic [15:0]         out_distance,
	output logic [14:0]         out_width,
	output logic [9:0]          out_points
);
	import lsc_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_EMIT, S_APPLY} state_t;

	state_t      state_q;
	op_t         op_q;
	logic        cur_valid_q;
	logic [14:0] cur_first_q;
	logic [14:0] cur_last_q;
	logic [9:0]  cur_count_q;
	logic [25:0] cur_sum_q;
	logic        best_valid_q;
	logic [14:0] best_center_q;
	logic [15:0] best_avg_q;
	logic [14:0] best_width_q;
	logic [9:0]  best_count_q;
	logic [15:0] cl_width_q;
	logic [14:0] cl_center_q;
	logic [9:0]  cl_count_q;
	logic [15:0] width;
	logic [15:0] center_raw;
	logic [14:0] center;
	logic        need_close;
	logic        div_done;
	logic [15:0] avg;
	logic        emit_fire;

	assign width = fwd_gap(cur_first_q, cur_last_q);
	assign center_raw = {1'b0, cur_first_q} + {1'b0, width[15:1]};
	assign center = (center_raw >= FullTurn) ? 15'(center_raw - FullTurn) : center_raw[14:0];
	assign need_close = cur_valid_q && (op_q.start || !op_q.kept ||
		!(op_q.near && cur_count_q < 10'(COUNT_LIMIT)));
	assign pop = (state_q == S_IDLE) && op_valid;
	assign emit_fire = (state_q == S_EMIT) && (!out_valid || out_ready);

	lsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_CHECK && need_close),
		.dividend (cur_sum_q),
		.divisor  (cur_count_q),
		.done     (div_done),
		.quotient (avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			cur_valid_q <= 1'b0;
			cur_first_q <= '0;
			cur_last_q <= '0;
			cur_count_q <= '0;
			cur_sum_q <= '0;
			best_valid_q <= 1'b0;
			best_center_q <= '0;
			best_avg_q <= '0;
			best_width_q <= '0;
			best_count_q <= '0;
			cl_width_q <= '0;
			cl_center_q <= '0;
			cl_count_q <= '0;
			out_valid <= 1'b0;
			out_found <= 1'b0;
			out_angle <= '0;
			out_distance <= '0;
			out_width <= '0;
			out_points <= '0;
		end else begin
			if (emit_fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						op_q <= op_in;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (need_close) begin
						cl_width_q <= width;
						cl_center_q <= center;
						cl_count_q <= cur_count_q;
						state_q <= S_DIV;
					end else if (op_q.start) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (cl_count_q >= 10'(MIN_POINTS) &&
							cl_width_q <= {1'b0, cfg.max_cluster_width} &&
							(!best_valid_q || avg < best_avg_q)) begin
							best_valid_q <= 1'b1;
							best_center_q <= cl_center_q;
							best_avg_q <= avg;
							best_width_q <= cl_width_q[14:0];
							best_count_q <= cl_count_q;
						end
						cur_valid_q <= 1'b0;
						cur_first_q <= '0;
						cur_last_q <= '0;
						cur_count_q <= '0;
						cur_sum_q <= '0;
						state_q <= op_q.start ? S_EMIT : S_APPLY;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						out_found <= best_valid_q;
						out_angle <= best_center_q;
						out_distance <= best_avg_q;
						out_width <= best_width_q;
						out_points <= best_count_q;
						best_valid_q <= 1'b0;
						best_center_q <= '0;
						best_avg_q <= '0;
						best_width_q <= '0;
						best_count_q <= '0;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (op_q.kept) begin
						if (!cur_valid_q) begin
							cur_valid_q <= 1'b1;
							cur_first_q <= op_q.angle;
							cur_last_q <= op_q.angle;
							cur_count_q <= 10'd1;
							cur_sum_q <= 26'(op_q.distance);
						end else begin
							cur_last_q <= op_q.angle;
							cur_count_q <= cur_count_q + 1'b1;
							cur_sum_q <= cur_sum_q + 26'(op_q.distance);
						end
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cur_count: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> cur_count_q != '0) else $error("open cluster with no points");
	a_best_count: assert property (@(posedge clk) disable iff (!arst_n)
		best_valid_q |-> best_count_q >= 10'(MIN_POINTS)) else $error("best too small");
	a_div_cur: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cur_valid_q) else $error("divide without cluster");
	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> op_q.start) else $error("emit without revolution start");

endmodule
`default_nettype wire

// ===== design/lidar_sweep_cluster_detector_core.sv =====
// Top level of the lidar sweep cluster detector: config registers, front, queue, back.
//
//  channel  | handshake                  | beat
//  point    | point_valid / point_ready  | point_angle, point_distance, point_quality,
//           |                            | revolution_start
//  object   | object_valid / object_ready| object_found, object_angle, object_distance,
//           |                            | object_width, object_points
//  config   | cfg_we                     | cfg_index, cfg_data
//
// In the back end a point passes the check and apply states, and a revolution start
// also the emit state; closing a cluster adds a 26-step serial divide for its average.
// The front takes a beat per cycle while the 4-entry queue has room.
// A revolution start waits in the back end until the result register is free.
// Reset is asynchronous; all but the queue store and divider data return to defaults.
`timescale 1ns / 1ps
`default_nettype none
module lidar_sweep_cluster_detector_core #(
	parameter int MIN_POINTS = 3,
	parameter int MAX_CLUSTER_POINTS = 1023
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	input  wire         point_valid,
	output logic        point_ready,
	input  wire  [14:0] point_angle,
	input  wire  [15:0] point_distance,
	input  wire  [5:0]  point_quality,
	input  wire         revolution_start,
	output logic        object_valid,
	input  wire         object_ready,
	output logic        object_found,
	output logic [14:0] object_angle,
	output logic [15:0] object_distance,
	output logic [14:0] object_width,
	output logic [9:0]  object_points
);
	import lsc_pkg::*;

	localparam int CountLimit = (MAX_CLUSTER_POINTS > 1023) ? 1023 : MAX_CLUSTER_POINTS;

	cfg_t cfg_q;
	op_t  push_op;
	op_t  head;
	logic push;
	logic pop;
	logic not_full;
	logic not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_distance <= 16'd400;
			cfg_q.max_distance <= 16'd4000;
			cfg_q.quality_floor <= 6'd10;
			cfg_q.window_start_angle <= 15'd19200;
			cfg_q.window_end_angle <= 15'd3840;
			cfg_q.max_angle_gap <= 15'd192;
			cfg_q.max_distance_gap <= 16'd400;
			cfg_q.max_cluster_width <= 15'd1920;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegMinDistance:    cfg_q.min_distance <= cfg_data;
				RegMaxDistance:    cfg_q.max_distance <= cfg_data;
				RegMinQuality:     cfg_q.quality_floor <= cfg_data[5:0];
				RegWindowStart:    cfg_q.window_start_angle <= cfg_data[14:0];
				RegWindowEnd:      cfg_q.window_end_angle <= cfg_data[14:0];
				RegMaxAngleGap:    cfg_q.max_angle_gap <= cfg_data[14:0];
				RegMaxDistanceGap: cfg_q.max_distance_gap <= cfg_data;
				RegMaxWidth:       cfg_q.max_cluster_width <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	lsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (point_valid),
		.in_ready    (point_ready),
		.angle_in    (point_angle),
		.distance_in (point_distance),
		.quality_in  (point_quality),
		.start_in    (revolution_start),
		.push        (push),
		.op          (push_op),
		.queue_ready (not_full)
	);

	lsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	lsc_back #(
		.MIN_POINTS  (MIN_POINTS),
		.COUNT_LIMIT (CountLimit)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.op_valid     (not_empty),
		.op_in        (head),
		.pop          (pop),
		.out_valid    (object_valid),
		.out_ready    (object_ready),
		.out_found    (object_found),
		.out_angle    (object_angle),
		.out_distance (object_distance),
		.out_width    (object_width),
		.out_points   (object_points)
	);

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Lidar sweep cluster detector bench: directed and random sweeps checked by a built-in predictor.
`timescale 1ns / 1ps
module tb_top;
	import lsc_pkg::*;

	localparam int unsigned Turn = 23040;
	localparam int unsigned CountCap = 1023;
	localparam int unsigned MinPts = 3;
	localparam int WatchLimit = 20000;

	typedef struct {
		logic [14:0] ang;
		logic [15:0] range_mm4;
		logic [5:0]  qual;
		logic        rev;
	} point_t;

	typedef struct {
		logic        found;
		logic [14:0] ang;
		logic [15:0] range_mm4;
		logic [14:0] width;
		logic [9:0]  pts;
	} object_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic point_valid, point_ready;
	logic [14:0] point_angle;
	logic [15:0] point_distance;
	logic [5:0] point_quality;
	logic revolution_start;
	logic object_valid, object_ready;
	logic object_found;
	logic [14:0] object_angle;
	logic [15:0] object_distance;
	logic [14:0] object_width;
	logic [9:0] object_points;

	lidar_sweep_cluster_detector_core i_dut (.*);

	point_t pending_points[$];
	object_t expected_objects[$];
	int errors = 0;
	int cycle = 0;
	int idle_cnt = 0;

	// predictor configuration and state
	int unsigned c_min_d, c_max_d, c_min_q, c_win_s, c_win_e, c_agap, c_dgap, c_width;
	bit run_valid, last_valid, best_valid;
	int unsigned run_first, run_last, run_count, run_sum, last_ang, last_dist;
	int unsigned best_center, best_avg, best_width, best_count;

	function automatic int unsigned turn_gap(int unsigned from, int unsigned to);
		return (to >= from) ? to - from : to + Turn - from;
	endfunction

	task automatic finish_run();
		int unsigned w, c, avg;
		if (!run_valid) return;
		w = turn_gap(run_first, run_last);
		c = run_first + (w >> 1);
		if (c >= Turn) c -= Turn;
		avg = run_count ? run_sum / run_count : 0;
		if (run_count >= MinPts && w <= c_width && (!best_valid || avg < best_avg)) begin
			best_valid = 1;
			best_center = c;
			best_avg = avg;
			best_width = w;
			best_count = run_count;
		end
		run_valid = 0;
		run_first = 0;
		run_last = 0;
		run_count = 0;
		run_sum = 0;
	endtask

	task automatic start_run(int unsigned a, int unsigned d);
		run_valid = 1;
		run_first = a;
		run_last = a;
		run_count = 1;
		run_sum = d;
	endtask

	task automatic predict_point(point_t p);
		int unsigned a, d, q, dg;
		bit kept, adjacent;
		object_t o;
		a = 32'(p.ang);
		d = 32'(p.range_mm4);
		q = 32'(p.qual);
		if (a >= Turn) a -= Turn;
		if (p.rev) begin
			finish_run();
			o.found = best_valid;
			o.ang = 15'(best_center);
			o.range_mm4 = 16'(best_avg);
			o.width = 15'(best_width);
			o.pts = 10'(best_count);
			expected_objects.push_back(o);
			best_valid = 0;
			best_center = 0;
			best_avg = 0;
			best_width = 0;
			best_count = 0;
			last_valid = 0;
		end
		kept = d >= c_min_d && d <= c_max_d && q >= c_min_q;
		if (c_win_s <= c_win_e) kept = kept && a >= c_win_s && a <= c_win_e;
		else kept = kept && (a >= c_win_s || a <= c_win_e);
		if (!kept) begin
			finish_run();
			last_valid = 0;
			return;
		end
		if (!run_valid) start_run(a, d);
		else begin
			dg = d >= last_dist ? d - last_dist : last_dist - d;
			adjacent = last_valid && turn_gap(last_ang, a) <= c_agap && dg <= c_dgap;
			if (adjacent && run_count < CountCap) begin
				run_last = a;
				run_count++;
				run_sum += d;
			end else begin
				finish_run();
				start_run(a, d);
			end
		end
		last_ang = a;
		last_dist = d;
		last_valid = 1;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// no idling on either side in this window
	wire calm = cycle >= 3000 && cycle < 9000;

	// point driver
	always @(posedge clk or negedge arst_n) begin
		point_t it;
		logic fire;
		if (!arst_n) begin
			point_valid <= 0;
			point_angle <= '0;
			point_distance <= '0;
			point_quality <= '0;
			revolution_start <= 0;
		end else begin
			fire = point_valid && point_ready;
			if (fire) begin
				it.ang = point_angle;
				it.range_mm4 = point_distance;
				it.qual = point_quality;
				it.rev = revolution_start;
				predict_point(it);
			end
			if (!point_valid || fire) begin
				if (pending_points.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
					it = pending_points.pop_front();
					point_valid <= 1;
					point_angle <= it.ang;
					point_distance <= it.range_mm4;
					point_quality <= it.qual;
					revolution_start <= it.rev;
				end else begin
					point_valid <= 0;
				end
			end
		end
	end

	// object monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		object_t e;
		if (!arst_n) begin
			object_ready <= 0;
		end else begin
			cycle <= cycle + 1;
			object_ready <= calm || $urandom_range(99) >= 26;
			if ((object_valid && object_ready) || (point_valid && point_ready)) idle_cnt <= 0;
			else idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= WatchLimit) begin
				$display("FAILURE");
				$finish;
			end
			if (object_valid && object_ready) begin
				if (expected_objects.size() == 0) begin
					$error("object beat with nothing expected");
					errors++;
				end else begin
					e = expected_objects.pop_front();
					if (object_found !== e.found) begin
						$error("object_found exp %0d got %0d", e.found, object_found);
						errors++;
					end
					if (object_angle !== e.ang) begin
						$error("object_angle exp %0d got %0d", e.ang, object_angle);
						errors++;
					end
					if (object_distance !== e.range_mm4) begin
						$error("object_distance exp %0d got %0d", e.range_mm4, object_distance);
						errors++;
					end
					if (object_width !== e.width) begin
						$error("object_width exp %0d got %0d", e.width, object_width);
						errors++;
					end
					if (object_points !== e.pts) begin
						$error("object_points exp %0d got %0d", e.pts, object_points);
						errors++;
					end
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		case (idx)
			RegMinDistance:    c_min_d = val & 16'hFFFF;
			RegMaxDistance:    c_max_d = val & 16'hFFFF;
			RegMinQuality:     c_min_q = val & 6'h3F;
			RegWindowStart:    c_win_s = val & 15'h7FFF;
			RegWindowEnd:      c_win_e = val & 15'h7FFF;
			RegMaxAngleGap:    c_agap = val & 15'h7FFF;
			RegMaxDistanceGap: c_dgap = val & 16'hFFFF;
			RegMaxWidth:       c_width = val & 15'h7FFF;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_config(int unsigned mnd, mxd, mq, ws, we, ag, dg, w);
		write_reg(RegMinDistance, mnd);
		write_reg(RegMaxDistance, mxd);
		write_reg(RegMinQuality, mq);
		write_reg(RegWindowStart, ws);
		write_reg(RegWindowEnd, we);
		write_reg(RegMaxAngleGap, ag);
		write_reg(RegMaxDistanceGap, dg);
		write_reg(RegMaxWidth, w);
	endtask

	task automatic drain();
		while (pending_points.size() > 0 || point_valid || expected_objects.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic add_point(int unsigned a, int unsigned d, int unsigned q, bit r);
		point_t p;
		p.ang = 15'(a);
		p.range_mm4 = 16'(d);
		p.qual = 6'(q);
		p.rev = r;
		pending_points.push_back(p);
	endtask

	// one revolution of mostly clustered points around a few objects
	task automatic add_sweep(int n, int unsigned step_max);
		int unsigned a, d, q;
		a = $urandom_range(Turn - 1);
		d = $urandom_range(300, 5000);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8) begin
				add_point($urandom_range(32767), $urandom_range(65535), $urandom_range(63),
					i == 0);
			end else begin
				if ($urandom_range(99) < 10) begin
					d = $urandom_range(200, 6000);
					a = (a + $urandom_range(100, 2000)) % Turn;
				end else begin
					a = (a + $urandom_range(step_max)) % Turn;
					d = d + $urandom_range(450) - 225;
					if (d > 65535) d = 65535;
				end
				q = $urandom_range(99) < 10 ? $urandom_range(15) : $urandom_range(8, 63);
				add_point((a < 9728 && $urandom_range(9) == 0) ? a + Turn : a, d, q, i == 0);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		c_min_d = 400; c_max_d = 4000; c_min_q = 10; c_win_s = 19200;
		c_win_e = 3840; c_agap = 192; c_dgap = 400; c_width = 1920;
		run_valid = 0; run_first = 0; run_last = 0; run_count = 0; run_sum = 0;
		last_valid = 0; last_ang = 0; last_dist = 0;
		best_valid = 0; best_center = 0; best_avg = 0; best_width = 0; best_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed, reset config: empty revolution, field extremes, cluster across zero
		add_point(0, 0, 0, 1);
		add_point(32767, 65535, 63, 0);
		add_point(23040, 400, 10, 0);
		add_point(22900, 1000, 63, 0);
		add_point(22990, 1100, 40, 0);
		add_point(23039, 1050, 40, 0);
		add_point(23100, 1000, 40, 0);
		add_point(100, 900, 40, 0);
		add_point(500, 4000, 9, 0);
		add_point(3840, 4000, 10, 0);
		add_point(3900, 3990, 10, 0);
		add_point(19200, 2000, 20, 1);
		add_point(19300, 2100, 20, 0);
		add_point(19400, 2150, 20, 0);
		add_point(1000, 500, 30, 1);
		add_point(0, 0, 0, 1);
		drain();
		for (int i = 0; i < 4; i++) add_sweep($urandom_range(20, 60), 200);
		add_point(0, 0, 0, 1);
		drain();

		// everything accepted, widest limits
		set_config(0, 65535, 0, 0, 23039, 23039, 65535, 23039);
		for (int i = 0; i < 2; i++) add_sweep($urandom_range(20, 60), 3000);
		// full cluster
		for (int i = 0; i < 1030; i++) add_point(5000, 1234 + (i % 3), 63, i == 0);
		add_point(0, 0, 0, 1);
		drain();

		// tight limits, narrow window
		set_config(1000, 1000, 63, 5000, 5000, 0, 0, 0);
		for (int i = 0; i < 2; i++) add_sweep($urandom_range(20, 40), 2);
		for (int i = 0; i < 4; i++) add_point(5000, 1000, 63, i == 0);
		add_point(0, 0, 0, 1);
		drain();

		// random settings
		for (int k = 0; k < 3; k++) begin
			set_config($urandom_range(0, 800), $urandom_range(3000, 65535), $urandom_range(30),
				$urandom_range(Turn - 1), $urandom_range(Turn - 1), $urandom_range(50, 400),
				$urandom_range(100, 800), $urandom_range(300, 4000));
			for (int i = 0; i < 2; i++) add_sweep($urandom_range(20, 60), 250);
			add_point(0, 0, 0, 1);
			drain();
		end

		// back to reset values
		set_config(400, 4000, 10, 19200, 3840, 192, 400, 1920);
		add_sweep($urandom_range(20, 60), 200);
		add_point(0, 0, 0, 1);
		drain();

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
design/lsc_pkg.sv
design/lsc_front.sv
design/lsc_queue.sv
design/lsc_div.sv
design/lsc_back.sv
design/lidar_sweep_cluster_detector_core.sv
tb/tb_top.sv
